/* hdl/ugns_pkg.sv */
// Shared widths, codes and controller/datapath bundles for the grid neighbour store.
package ugns_pkg;

  localparam int COORD_W    = 24;
  localparam int RAD_W      = 24;
  localparam int BOUND_W    = 16;
  localparam int SHIFT_W    = 4;
  localparam int SPAN_W     = 16;
  localparam int OP_W       = 2;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_OUTSIDE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT  = 3'd4;

  typedef struct packed {
    logic latch;
    logic setup1;
    logic setup2;
    logic prod;
    logic idx;
    logic fill_chk;
    logic add_wr;
    logic set_full;
    logic set_outside;
    logic pt_mul;
    logic pt_next;
    logic set_hit;
    logic bkt_next;
    logic sweep;
    logic sweep_rst;
  } ugns_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            in_area;
    logic            idx_ok;
    logic            fill_zero;
    logic            fill_full;
    logic            hit;
    logic            k_last;
    logic            col_last;
    logic            row_last;
    logic            sweep_last;
  } ugns_stat_t;

endpackage

/* hdl/uniform_grid_neighbor_store.sv */
// Top level: uniform grid neighbour store with command port, result strobe and register port.
//
//  channel  ports                                            handshake
//  input    in_operation in_point_x in_point_y in_radius     start high, busy low
//  result   out_has_neighbor out_status                      out_strobe, one cycle
//  config   cfg_index cfg_data                               cfg_valid and cfg_ready
//
// Add stops early when the point lies outside the area; clear sweeps the whole fill table.
// Query walks each bucket row, each bucket covered and each stored point tested in turn,
// ending at the first hit; the single read port of each memory sets the steps.
// After reset, and after every register write, a sweep of all GRID_CELLS buckets empties the
// fill table; busy stays high through it. Results cannot be stalled: out_strobe marks
// each one for exactly one cycle. Registers are accepted every cycle (cfg_ready is high).
module uniform_grid_neighbor_store import ugns_pkg::*; #(
  parameter int GRID_CELLS    = 4096,
  parameter int CELL_CAPACITY = 8,
  parameter int FRAC_BITS     = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [OP_W-1:0]           in_operation,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  input  logic [RAD_W-1:0]          in_radius,
  output logic                      out_strobe,
  output logic                      out_has_neighbor,
  output logic [STAT_W-1:0]         out_status,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  ugns_cmd_t  cmd;
  ugns_stat_t stat;
  logic       cfg_we;

  assign cfg_ready = 1'b1;
  // indexes past the last register are dropped
  assign cfg_we    = cfg_valid && (cfg_index <= CFG_SHIFT);

  ugns_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .cfg_valid  (cfg_valid),
    .cfg_we     (cfg_we),
    .stat       (stat),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd)
  );

  ugns_dp #(
    .GRID_CELLS    (GRID_CELLS),
    .CELL_CAPACITY (CELL_CAPACITY),
    .FRAC_BITS     (FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_operation     (in_operation),
    .in_point_x       (in_point_x),
    .in_point_y       (in_point_y),
    .in_radius        (in_radius),
    .cmd              (cmd),
    .stat             (stat),
    .out_has_neighbor (out_has_neighbor),
    .out_status       (out_status)
  );

endmodule

/* hdl/ugns_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module ugns_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/ugns_ctrl.sv */
// Sequencer for add, query walk, bucket sweep and result strobe.
module ugns_ctrl import ugns_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       cfg_valid,
  input  logic       cfg_we,
  input  ugns_stat_t stat,
  output logic       busy,
  output logic       out_strobe,
  output ugns_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SWEEP = 4'd1;
  localparam logic [3:0] S_CLR   = 4'd2;
  localparam logic [3:0] S_SET1  = 4'd3;
  localparam logic [3:0] S_SET2  = 4'd4;
  localparam logic [3:0] S_IMUL  = 4'd5;
  localparam logic [3:0] S_IADD  = 4'd6;
  localparam logic [3:0] S_FRD   = 4'd7;
  localparam logic [3:0] S_FCHK  = 4'd8;
  localparam logic [3:0] S_PRD   = 4'd9;
  localparam logic [3:0] S_PMUL  = 4'd10;
  localparam logic [3:0] S_PCMP  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0] state_r, state_nxt;

  function automatic logic [3:0] after_bkt(input ugns_stat_t s);
    logic [3:0] n;
    if (!s.col_last) begin
      n = S_IADD;
    end else if (!s.row_last) begin
      n = S_IMUL;
    end else begin
      n = S_DONE;
    end
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start && !cfg_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_SET1;
        end
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) state_nxt = S_IDLE;
      end
      S_CLR: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) state_nxt = S_DONE;
      end
      S_SET1: begin
        cmd.setup1 = 1'b1;
        state_nxt  = S_SET2;
      end
      S_SET2: begin
        cmd.setup2 = 1'b1;
        case (stat.op)
          OP_ADD: begin
            if (!stat.in_area) begin
              cmd.set_outside = 1'b1;
              state_nxt       = S_DONE;
            end else begin
              state_nxt = S_IMUL;
            end
          end
          OP_QUERY: state_nxt = stat.empty ? S_DONE : S_IMUL;
          OP_CLEAR: begin
            cmd.sweep_rst = 1'b1;
            state_nxt     = S_CLR;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_IMUL: begin
        cmd.prod  = 1'b1;
        state_nxt = S_IADD;
      end
      S_IADD: begin
        cmd.idx   = 1'b1;
        state_nxt = S_FRD;
      end
      S_FRD: begin
        if (stat.idx_ok) begin
          state_nxt = S_FCHK;
        end else if (stat.op == OP_ADD) begin
          cmd.set_outside = 1'b1;
          state_nxt       = S_DONE;
        end else begin
          cmd.bkt_next = 1'b1;
          state_nxt    = after_bkt(stat);
        end
      end
      S_FCHK: begin
        cmd.fill_chk = 1'b1;
        if (stat.op == OP_ADD) begin
          if (stat.fill_full) begin
            cmd.set_full = 1'b1;
          end else begin
            cmd.add_wr = 1'b1;
          end
          state_nxt = S_DONE;
        end else if (stat.fill_zero) begin
          cmd.bkt_next = 1'b1;
          state_nxt    = after_bkt(stat);
        end else begin
          state_nxt = S_PRD;
        end
      end
      S_PRD: state_nxt = S_PMUL;
      S_PMUL: begin
        cmd.pt_mul = 1'b1;
        state_nxt  = S_PCMP;
      end
      S_PCMP: begin
        if (stat.hit) begin
          cmd.set_hit = 1'b1;
          state_nxt   = S_DONE;
        end else if (stat.k_last) begin
          cmd.bkt_next = 1'b1;
          state_nxt    = after_bkt(stat);
        end else begin
          cmd.pt_next = 1'b1;
          state_nxt   = S_PRD;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    // a register write empties every bucket
    if (cfg_we) begin
      cmd.sweep_rst = 1'b1;
      state_nxt     = S_SWEEP;
    end
  end

  assign busy       = (state_r != S_IDLE) || cfg_valid;
  assign out_strobe = (state_r == S_DONE);

  assert property (@(posedge clk) disable iff (!rst_n) cfg_we |=> busy)
    else $error("register write did not start a bucket sweep");
  assert property (@(posedge clk) disable iff (!rst_n) out_strobe |=> !out_strobe)
    else $error("result strobe longer than one cycle");
  assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
    else $error("accepted beat left the sequencer idle");

endmodule

/* hdl/ugns_dp.sv */
// Datapath: registers, bucket geometry, fill and point memories, distance test.
module ugns_dp import ugns_pkg::*; #(
  parameter int GRID_CELLS    = 4096,
  parameter int CELL_CAPACITY = 8,
  parameter int FRAC_BITS     = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic [OP_W-1:0]              in_operation,
  input  logic signed [COORD_W-1:0]    in_point_x,
  input  logic signed [COORD_W-1:0]    in_point_y,
  input  logic [RAD_W-1:0]             in_radius,
  input  ugns_cmd_t                    cmd,
  output ugns_stat_t                   stat,
  output logic                         out_has_neighbor,
  output logic [STAT_W-1:0]            out_status
);

  localparam int IDX_W    = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
  localparam int FILL_W   = $clog2(CELL_CAPACITY + 1);
  localparam int ST_DEPTH = GRID_CELLS * CELL_CAPACITY;
  localparam int ST_AW    = (ST_DEPTH > 1) ? $clog2(ST_DEPTH) : 1;
  localparam int PT_W     = 2 * COORD_W;
  localparam int EXT_W    = COORD_W + 2;
  localparam int IDXF_W   = 2 * SPAN_W + 1;
  localparam int SQ_W     = 2 * COORD_W + 1;

  // configuration
  logic signed [BOUND_W-1:0] left_r, top_r, right_r, bottom_r;
  logic [SHIFT_W-1:0]        shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      top_r    <= '0;
      right_r  <= 16'sd256;
      bottom_r <= 16'sd256;
      shift_r  <= 4'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEFT:   left_r   <= cfg_data;
        CFG_TOP:    top_r    <= cfg_data;
        CFG_RIGHT:  right_r  <= cfg_data;
        CFG_BOTTOM: bottom_r <= cfg_data;
        CFG_SHIFT:  shift_r  <= cfg_data[SHIFT_W-1:0];
        default:    shift_r  <= shift_r;
      endcase
    end
  end

  // grid size in buckets, rounded up
  logic signed [BOUND_W:0]   wdt, hgt;
  logic [BOUND_W+1:0]        rnd_mask, wsum, hsum;
  logic [SPAN_W-1:0]         cols_r, cols_nxt, rows_r, rows_nxt;

  always_comb begin
    wdt      = {right_r[BOUND_W-1], right_r} - {left_r[BOUND_W-1], left_r};
    hgt      = {bottom_r[BOUND_W-1], bottom_r} - {top_r[BOUND_W-1], top_r};
    rnd_mask = (18'd1 << shift_r) - 18'd1;
    wsum     = {1'b0, wdt} + rnd_mask;
    hsum     = {1'b0, hgt} + rnd_mask;
    cols_nxt = (wdt <= 0) ? '0 : SPAN_W'(wsum >> shift_r);
    rows_nxt = (hgt <= 0) ? '0 : SPAN_W'(hsum >> shift_r);
  end

  always_ff @(posedge clk) begin
    cols_r <= cols_nxt;
    rows_r <= rows_nxt;
  end

  // item
  logic [OP_W-1:0]           op_r;
  logic signed [COORD_W-1:0] px_r, py_r;
  logic [RAD_W-1:0]          r_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r <= in_operation;
      px_r <= in_point_x;
      py_r <= in_point_y;
      r_r  <= in_radius;
    end
  end

  function automatic logic signed [EXT_W-1:0] clamp(input logic signed [EXT_W-1:0] v,
                                                    input logic signed [EXT_W-1:0] lo,
                                                    input logic signed [EXT_W-1:0] hi);
    logic signed [EXT_W-1:0] c;
    c = v;
    if (c > hi) c = hi;
    if (c < lo) c = lo;
    return c;
  endfunction

  logic signed [COORD_W-1:0] ix, iy;
  logic [RAD_W-1:0]          ir;
  logic signed [EXT_W-1:0]   ixe, iye, ire, lox, hix, loy, hiy;
  logic signed [EXT_W-1:0]   xa, xb, ya, yb, x0v, y0v, dx0, dx1, dy0, dy1;

  always_comb begin
    ix  = px_r >>> FRAC_BITS;
    iy  = py_r >>> FRAC_BITS;
    ir  = r_r >> FRAC_BITS;
    ixe = {{2{ix[COORD_W-1]}}, ix};
    iye = {{2{iy[COORD_W-1]}}, iy};
    ire = {2'b00, ir};
    lox = {{(EXT_W-BOUND_W){left_r[BOUND_W-1]}}, left_r};
    loy = {{(EXT_W-BOUND_W){top_r[BOUND_W-1]}}, top_r};
    hix = {{(EXT_W-BOUND_W){right_r[BOUND_W-1]}}, right_r} - 26'sd1;
    hiy = {{(EXT_W-BOUND_W){bottom_r[BOUND_W-1]}}, bottom_r} - 26'sd1;
    xa  = ixe - ire;
    xb  = ixe + ire;
    ya  = iye - ire;
    yb  = iye + ire;
    x0v = (op_r == OP_ADD) ? ixe : clamp(xa, lox, hix);
    y0v = (op_r == OP_ADD) ? iye : clamp(ya, loy, hiy);
    dx0 = x0v - lox;
    dy0 = y0v - loy;
    dx1 = clamp(xb, lox, hix) - lox;
    dy1 = clamp(yb, loy, hiy) - loy;
  end

  logic [SPAN_W-1:0]     ox0_r, ox1_r, oy0_r, oy1_r;
  logic                  inside_r, empty_r;
  logic [2*RAD_W-1:0]    rsq_r;

  always_ff @(posedge clk) begin
    if (cmd.setup1) begin
      ox0_r    <= dx0[SPAN_W-1:0];
      ox1_r    <= dx1[SPAN_W-1:0];
      oy0_r    <= dy0[SPAN_W-1:0];
      oy1_r    <= dy1[SPAN_W-1:0];
      inside_r <= (ixe >= lox) && (ixe <= hix) && (iye >= loy) && (iye <= hiy);
      empty_r  <= (cols_r == '0) || (rows_r == '0);
      rsq_r    <= r_r * r_r;
    end
  end

  // bucket walk
  logic [SPAN_W-1:0]   cx_r, cy_r, cx0_r;
  logic [SPAN_W:0]     cx1_r, cy1_r;
  logic [2*SPAN_W-1:0] prod_r;
  logic [IDXF_W-1:0]   idx_r;
  logic                col_last, row_last;

  assign col_last = ({1'b0, cx_r} + 17'd1) >= cx1_r;
  assign row_last = ({1'b0, cy_r} + 17'd1) >= cy1_r;

  always_ff @(posedge clk) begin
    if (cmd.setup2) begin
      cx_r  <= ox0_r >> shift_r;
      cx0_r <= ox0_r >> shift_r;
      cy_r  <= oy0_r >> shift_r;
      cx1_r <= {1'b0, (ox1_r >> shift_r)} + 17'd1;
      cy1_r <= {1'b0, (oy1_r >> shift_r)} + 17'd1;
    end else if (cmd.bkt_next) begin
      if (!col_last) begin
        cx_r <= cx_r + 16'd1;
      end else if (!row_last) begin
        cy_r <= cy_r + 16'd1;
        cx_r <= cx0_r;
      end
    end
    if (cmd.prod) prod_r <= cols_r * cy_r;
    if (cmd.idx)  idx_r  <= {{(SPAN_W+1){1'b0}}, cx_r} + {1'b0, prod_r};
  end

  logic [IDX_W-1:0] idx_a;
  logic [ST_AW-1:0] st_base, st_raddr, st_waddr;
  logic [FILL_W-1:0] fill_q, fill_wdata, n_r, k_r;
  logic [IDX_W-1:0] sweep_r, fill_waddr;
  logic             fill_we;
  logic [PT_W-1:0]  st_rdata;

  assign idx_a    = idx_r[IDX_W-1:0];
  assign st_base  = ST_AW'(idx_a) * ST_AW'(CELL_CAPACITY);
  assign st_raddr = st_base + ST_AW'(k_r);
  assign st_waddr = st_base + ST_AW'(fill_q);

  // sweep counter clears the fill table one bucket a cycle
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.sweep_rst) begin
      sweep_r <= '0;
    end else if (cmd.sweep) begin
      sweep_r <= sweep_r + IDX_W'(1);
    end
  end

  assign fill_we    = cmd.sweep || cmd.add_wr;
  assign fill_waddr = cmd.sweep ? sweep_r : idx_a;
  assign fill_wdata = cmd.sweep ? '0 : fill_q + FILL_W'(1);

  ugns_ram #(.WIDTH(FILL_W), .DEPTH(GRID_CELLS)) u_fill (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .raddr (idx_a),
    .rdata (fill_q)
  );

  ugns_ram #(.WIDTH(PT_W), .DEPTH(ST_DEPTH)) u_points (
    .clk   (clk),
    .we    (cmd.add_wr),
    .waddr (st_waddr),
    .wdata ({px_r, py_r}),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.fill_chk) begin
      n_r <= fill_q;
      k_r <= '0;
    end else if (cmd.pt_next) begin
      k_r <= k_r + FILL_W'(1);
    end
  end

  // squared distance
  logic signed [COORD_W-1:0]   sx, sy;
  logic signed [COORD_W:0]     ddx, ddy;
  logic signed [2*COORD_W+1:0] pxx, pyy;
  logic [SQ_W-1:0]             sq_x_r, sq_y_r;
  logic                        hit;

  always_comb begin
    sx  = st_rdata[PT_W-1:COORD_W];
    sy  = st_rdata[COORD_W-1:0];
    ddx = {px_r[COORD_W-1], px_r} - {sx[COORD_W-1], sx};
    ddy = {py_r[COORD_W-1], py_r} - {sy[COORD_W-1], sy};
    pxx = ddx * ddx;
    pyy = ddy * ddy;
    hit = ({1'b0, sq_x_r} + {1'b0, sq_y_r}) < {2'b00, rsq_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.pt_mul) begin
      sq_x_r <= pxx[SQ_W-1:0];
      sq_y_r <= pyy[SQ_W-1:0];
    end
  end

  // result
  logic              hit_r;
  logic [STAT_W-1:0] status_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.latch) begin
      hit_r    <= 1'b0;
      status_r <= ST_DONE;
    end else begin
      if (cmd.set_hit)     hit_r    <= 1'b1;
      if (cmd.set_full)    status_r <= ST_FULL;
      if (cmd.set_outside) status_r <= ST_OUTSIDE;
    end
  end

  assign out_has_neighbor = hit_r;
  assign out_status       = status_r;

  assign stat.op         = op_r;
  assign stat.empty      = empty_r;
  assign stat.in_area    = inside_r;
  assign stat.idx_ok     = idx_r < IDXF_W'(GRID_CELLS);
  assign stat.fill_zero  = (fill_q == '0);
  assign stat.fill_full  = (fill_q >= FILL_W'(CELL_CAPACITY));
  assign stat.hit        = hit;
  assign stat.k_last     = ({1'b0, k_r} + {{FILL_W{1'b0}}, 1'b1}) >= {1'b0, n_r};
  assign stat.col_last   = col_last;
  assign stat.row_last   = row_last;
  assign stat.sweep_last = (sweep_r == IDX_W'(GRID_CELLS - 1));

  assert property (@(posedge clk) disable iff (!rst_n) cmd.pt_mul |-> (k_r < n_r))
    else $error("point read beyond bucket fill");
  assert property (@(posedge clk) disable iff (!rst_n)
                   cmd.add_wr |-> (fill_q < FILL_W'(CELL_CAPACITY)))
    else $error("add written into a full bucket");
  assert property (@(posedge clk) disable iff (!rst_n) !(cmd.sweep && cmd.add_wr))
    else $error("fill table written by sweep and add together");

endmodule
